@@ hw/rtl/hjd_pkg.sv @@
// shared types, constants and jamo lookup tables for the hangul jamo decomposer
// no dependencies; imported by every module of the block
package hjd_pkg;

   localparam int unsigned RunMax     = 5;
   localparam int unsigned QueueDepth = 4;

   localparam logic [15:0] SylFirst  = 16'hAC00;
   localparam logic [15:0] SylLast   = 16'hD7A3;
   localparam logic [15:0] CmpCFirst = 16'h3131;
   localparam logic [15:0] CmpCLast  = 16'h314E;
   localparam logic [15:0] CmpVFirst = 16'h314F;
   localparam logic [15:0] CmpVLast  = 16'h3163;
   localparam logic [15:0] CnjLFirst = 16'h1100;
   localparam logic [15:0] CnjLLast  = 16'h1112;
   localparam logic [15:0] CnjVFirst = 16'h1161;
   localparam logic [15:0] CnjVLast  = 16'h1175;
   localparam logic [15:0] CnjTFirst = 16'h11A8;
   localparam logic [15:0] CnjTLast  = 16'h11C2;

   // off / 588 == (off * 28533) >> 24 for every syllable offset
   localparam logic [14:0] RecipPerL  = 15'd28533;
   localparam int unsigned PerLShift  = 24;
   localparam logic [9:0]  SylPerL    = 10'd588;
   // rest / 28 == (rest * 586) >> 14 for rest < 588
   localparam logic [9:0]  RecipPerV  = 10'd586;
   localparam int unsigned PerVShift  = 14;
   localparam logic [9:0]  SylPerV    = 10'd28;

   typedef logic [15:0] unit_type;
   typedef logic [4:0]  index_type;
   typedef logic [2:0]  count_type;

   typedef enum logic [2:0] {
      CLS_OTHER,
      CLS_SYL,
      CLS_CMP_C,
      CLS_CMP_V,
      CLS_CNJ_L,
      CLS_CNJ_V,
      CLS_CNJ_T
   } jamo_class_type;

   typedef struct packed {
      unit_type a;
      unit_type b;
   } jamo_pair_type;

   typedef struct packed {
      unit_type [RunMax-1:0] units;
      count_type             count;
   } run_type;

   typedef struct packed {
      jamo_class_type cls;
      unit_type       code;
      logic [13:0]    off;
      index_type      idx;
      index_type      li;
      logic [9:0]     rest;
      index_type      vi;
   } front_stage_type;

   function automatic unit_type initial_jamo(input index_type i);
      unit_type u;
      case (i)
         5'd0:  u = 16'h3131;
         5'd1:  u = 16'h3132;
         5'd2:  u = 16'h3134;
         5'd3:  u = 16'h3137;
         5'd4:  u = 16'h3138;
         5'd5:  u = 16'h3139;
         5'd6:  u = 16'h3141;
         5'd7:  u = 16'h3142;
         5'd8:  u = 16'h3143;
         5'd9:  u = 16'h3145;
         5'd10: u = 16'h3146;
         5'd11: u = 16'h3147;
         5'd12: u = 16'h3148;
         5'd13: u = 16'h3149;
         5'd14: u = 16'h314A;
         5'd15: u = 16'h314B;
         5'd16: u = 16'h314C;
         5'd17: u = 16'h314D;
         5'd18: u = 16'h314E;
         default: u = '0;
      endcase
      return u;
   endfunction

   function automatic jamo_pair_type medial_jamo(input index_type i);
      jamo_pair_type p;
      case (i)
         5'd0:  p = '{16'h314F, 16'h0000};
         5'd1:  p = '{16'h3150, 16'h0000};
         5'd2:  p = '{16'h3151, 16'h0000};
         5'd3:  p = '{16'h3152, 16'h0000};
         5'd4:  p = '{16'h3153, 16'h0000};
         5'd5:  p = '{16'h3154, 16'h0000};
         5'd6:  p = '{16'h3155, 16'h0000};
         5'd7:  p = '{16'h3156, 16'h0000};
         5'd8:  p = '{16'h3157, 16'h0000};
         5'd9:  p = '{16'h3157, 16'h314F};
         5'd10: p = '{16'h3157, 16'h3150};
         5'd11: p = '{16'h3157, 16'h3163};
         5'd12: p = '{16'h315B, 16'h0000};
         5'd13: p = '{16'h315C, 16'h0000};
         5'd14: p = '{16'h315C, 16'h3153};
         5'd15: p = '{16'h315C, 16'h3154};
         5'd16: p = '{16'h315C, 16'h3163};
         5'd17: p = '{16'h3160, 16'h0000};
         5'd18: p = '{16'h3161, 16'h0000};
         5'd19: p = '{16'h3161, 16'h3163};
         5'd20: p = '{16'h3163, 16'h0000};
         default: p = '0;
      endcase
      return p;
   endfunction

   function automatic jamo_pair_type final_jamo(input index_type i);
      jamo_pair_type p;
      case (i)
         5'd1:  p = '{16'h3131, 16'h0000};
         5'd2:  p = '{16'h3132, 16'h0000};
         5'd3:  p = '{16'h3131, 16'h3145};
         5'd4:  p = '{16'h3134, 16'h0000};
         5'd5:  p = '{16'h3134, 16'h3148};
         5'd6:  p = '{16'h3134, 16'h314E};
         5'd7:  p = '{16'h3137, 16'h0000};
         5'd8:  p = '{16'h3139, 16'h0000};
         5'd9:  p = '{16'h3139, 16'h3131};
         5'd10: p = '{16'h3139, 16'h3141};
         5'd11: p = '{16'h3139, 16'h3142};
         5'd12: p = '{16'h3139, 16'h3145};
         5'd13: p = '{16'h3139, 16'h314C};
         5'd14: p = '{16'h3139, 16'h314D};
         5'd15: p = '{16'h3139, 16'h314E};
         5'd16: p = '{16'h3141, 16'h0000};
         5'd17: p = '{16'h3142, 16'h0000};
         5'd18: p = '{16'h3142, 16'h3145};
         5'd19: p = '{16'h3145, 16'h0000};
         5'd20: p = '{16'h3146, 16'h0000};
         5'd21: p = '{16'h3147, 16'h0000};
         5'd22: p = '{16'h3148, 16'h0000};
         5'd23: p = '{16'h314A, 16'h0000};
         5'd24: p = '{16'h314B, 16'h0000};
         5'd25: p = '{16'h314C, 16'h0000};
         5'd26: p = '{16'h314D, 16'h0000};
         5'd27: p = '{16'h314E, 16'h0000};
         default: p = '0;
      endcase
      return p;
   endfunction

   function automatic jamo_pair_type consonant_jamo(input index_type i);
      jamo_pair_type p;
      case (i)
         5'd0:  p = '{16'h3131, 16'h0000};
         5'd1:  p = '{16'h3132, 16'h0000};
         5'd2:  p = '{16'h3131, 16'h3145};
         5'd3:  p = '{16'h3134, 16'h0000};
         5'd4:  p = '{16'h3134, 16'h3148};
         5'd5:  p = '{16'h3134, 16'h314E};
         5'd6:  p = '{16'h3137, 16'h0000};
         5'd7:  p = '{16'h3138, 16'h0000};
         5'd8:  p = '{16'h3139, 16'h0000};
         5'd9:  p = '{16'h3139, 16'h3131};
         5'd10: p = '{16'h3139, 16'h3141};
         5'd11: p = '{16'h3139, 16'h3142};
         5'd12: p = '{16'h3139, 16'h3145};
         5'd13: p = '{16'h3139, 16'h314C};
         5'd14: p = '{16'h3139, 16'h314D};
         5'd15: p = '{16'h3139, 16'h314E};
         5'd16: p = '{16'h3141, 16'h0000};
         5'd17: p = '{16'h3142, 16'h0000};
         5'd18: p = '{16'h3143, 16'h0000};
         5'd19: p = '{16'h3142, 16'h3145};
         5'd20: p = '{16'h3145, 16'h0000};
         5'd21: p = '{16'h3146, 16'h0000};
         5'd22: p = '{16'h3147, 16'h0000};
         5'd23: p = '{16'h3148, 16'h0000};
         5'd24: p = '{16'h3149, 16'h0000};
         5'd25: p = '{16'h314A, 16'h0000};
         5'd26: p = '{16'h314B, 16'h0000};
         5'd27: p = '{16'h314C, 16'h0000};
         5'd28: p = '{16'h314D, 16'h0000};
         5'd29: p = '{16'h314E, 16'h0000};
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

@@ hw/rtl/hjd_front.sv @@
// front end: classifies each code unit, splits syllables, builds the jamo run
// depends on hjd_pkg; feeds hjd_queue
module hjd_front import hjd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  unit_type req_code_unit,
   input  logic     req_push,
   output logic     req_full,
   output logic     q_push,
   output run_type  q_run,
   input  logic     q_full
);

   logic            v1_ff, v2_ff, v3_ff, v4_ff;
   front_stage_type s1_ff, s2_ff, s3_ff, s4_ff;
   front_stage_type s1_in, s2_in, s3_in, s4_in;
   logic            rdy1, rdy2, rdy3, rdy4;

   logic [28:0]     prod_l;
   logic [18:0]     prod_v;
   logic [13:0]     li_x588;
   logic [9:0]      vi_x28;
   logic [9:0]      ti_full;
   index_type       ti;
   logic [15:0]     idx_diff;
   jamo_pair_type   pair_a, pair_b;
   unit_type        cand [RunMax];
   run_type         run;
   count_type       n;

   // stall ripples back from the queue
   assign rdy4     = !v4_ff || !q_full;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign req_full = !rdy1;

   // stage 1 input: classify
   always_comb begin
      s1_in      = '0;
      s1_in.code = req_code_unit;
      if (req_code_unit inside {[SylFirst:SylLast]}) begin
         s1_in.cls = CLS_SYL;
      end else if (req_code_unit inside {[CmpCFirst:CmpCLast]}) begin
         s1_in.cls = CLS_CMP_C;
      end else if (req_code_unit inside {[CmpVFirst:CmpVLast]}) begin
         s1_in.cls = CLS_CMP_V;
      end else if (req_code_unit inside {[CnjLFirst:CnjLLast]}) begin
         s1_in.cls = CLS_CNJ_L;
      end else if (req_code_unit inside {[CnjVFirst:CnjVLast]}) begin
         s1_in.cls = CLS_CNJ_V;
      end else if (req_code_unit inside {[CnjTFirst:CnjTLast]}) begin
         s1_in.cls = CLS_CNJ_T;
      end else begin
         s1_in.cls = CLS_OTHER;
      end
   end

   // stage 2 input: syllable offset, initial by reciprocal, table index
   always_comb begin
      s2_in     = s1_ff;
      s2_in.off = 14'(s1_ff.code - SylFirst);
      prod_l    = 29'(s2_in.off) * 29'(RecipPerL);
      s2_in.li  = prod_l[PerLShift +: 5];
      case (s1_ff.cls)
         CLS_CMP_C: idx_diff = s1_ff.code - CmpCFirst;
         CLS_CMP_V: idx_diff = s1_ff.code - CmpVFirst;
         CLS_CNJ_L: idx_diff = s1_ff.code - CnjLFirst;
         CLS_CNJ_V: idx_diff = s1_ff.code - CnjVFirst;
         // conjoining finals sit one past the empty final
         CLS_CNJ_T: idx_diff = s1_ff.code - CnjTFirst + 16'd1;
         default:   idx_diff = '0;
      endcase
      s2_in.idx = idx_diff[4:0];
   end

   // stage 3 input: remainder after the initial
   always_comb begin
      s3_in      = s2_ff;
      li_x588    = 14'(s2_ff.li) * 14'(SylPerL);
      s3_in.rest = 10'(s2_ff.off - li_x588);
   end

   // stage 4 input: medial by reciprocal
   always_comb begin
      s4_in    = s3_ff;
      prod_v   = 19'(s3_ff.rest) * 19'(RecipPerV);
      s4_in.vi = prod_v[PerVShift +: 5];
   end

   // stage 4: final index, table lookups, pack the run
   always_comb begin
      vi_x28  = 10'(10'(s4_ff.vi) * SylPerV);
      ti_full = s4_ff.rest - vi_x28;
      ti      = ti_full[4:0];
      pair_a  = '0;
      pair_b  = '0;
      for (int i = 0; i < RunMax; i++) begin
         cand[i] = '0;
      end
      case (s4_ff.cls)
         CLS_SYL: begin
            cand[0] = initial_jamo(s4_ff.li);
            pair_a  = medial_jamo(s4_ff.vi);
            pair_b  = final_jamo(ti);
         end
         CLS_CMP_C: pair_a  = consonant_jamo(s4_ff.idx);
         CLS_CMP_V: pair_a  = medial_jamo(s4_ff.idx);
         CLS_CNJ_L: cand[0] = initial_jamo(s4_ff.idx);
         CLS_CNJ_V: pair_a  = medial_jamo(s4_ff.idx);
         CLS_CNJ_T: pair_a  = final_jamo(s4_ff.idx);
         default:   pair_a  = '0;
      endcase
      if (s4_ff.cls == CLS_SYL) begin
         cand[1] = pair_a.a;
         cand[2] = pair_a.b;
         cand[3] = pair_b.a;
         cand[4] = pair_b.b;
      end else if (s4_ff.cls != CLS_CNJ_L) begin
         cand[0] = pair_a.a;
         cand[1] = pair_a.b;
      end
      // squeeze out empty slots
      run = '0;
      n   = '0;
      for (int i = 0; i < RunMax; i++) begin
         if (cand[i] != '0) begin
            run.units[n] = cand[i];
            n            = n + 3'd1;
         end
      end
      if (n == '0) begin
         run.units[0] = s4_ff.code;
         n            = 3'd1;
      end
      run.count = n;
   end

   assign q_push = v4_ff;
   assign q_run  = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_push;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) s1_ff <= s1_in;
      if (rdy2) s2_ff <= s2_in;
      if (rdy3) s3_ff <= s3_in;
      if (rdy4) s4_ff <= s4_in;
   end

endmodule

@@ hw/rtl/hjd_queue.sv @@
// short queue of finished jamo runs between front and back ends
// depends on hjd_pkg
module hjd_queue import hjd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  run_type push_run,
   output logic    full,
   input  logic    pop,
   output run_type pop_run,
   output logic    empty
);

   localparam int unsigned PtrW = $clog2(QueueDepth);
   localparam int unsigned CntW = $clog2(QueueDepth + 1);

   run_type         mem_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CntW'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_run = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PtrW'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + PtrW'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_run;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QueueDepth))
      else $error("queue count past depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[PtrW-1:0])
      else $error("queue pointers disagree with count");

endmodule

@@ hw/rtl/hjd_back.sv @@
// back end: serializes one jamo run into single units, one per cycle while rsp_pop takes each
// depends on hjd_pkg; drains hjd_queue
module hjd_back import hjd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  run_type  q_run,
   output logic     q_pop,
   output unit_type rsp_jamo_unit,
   output logic     rsp_run_last,
   output logic     rsp_empty,
   input  logic     rsp_pop
);

   run_type   cur_ff;
   count_type idx_ff, idx_in;
   logic      valid_ff, valid_in;
   logic      last;

   assign last          = (idx_ff == cur_ff.count - 3'd1);
   assign rsp_empty     = !valid_ff;
   assign rsp_jamo_unit = cur_ff.units[idx_ff];
   assign rsp_run_last  = last;

   // load the next run as the last beat of this one leaves, or when no run is held
   assign q_pop = !q_empty && (!valid_ff || (rsp_pop && last));

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (valid_ff && rsp_pop) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_run;
   end

   a_run_len: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cur_ff.count != '0 && cur_ff.count <= 3'(RunMax)))
      else $error("run length out of range");

   a_idx_in_run: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < cur_ff.count))
      else $error("beat index past end of run");

   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_pop) |=> (valid_ff && $stable(idx_ff)))
      else $error("unaccepted beat moved");

endmodule

@@ hw/rtl/hangul_jamo_decomposer_unit.sv @@
// a code unit passes the front stages, a queue entry and the serializer register
// throughput: one jamo beat per cycle while rsp_pop takes each, set by the single
//   output serializer; a run holds 1 to 5 beats, 2 to 5 for a syllable
// a 4-entry run queue lets the 4-stage front keep taking items while output stalls
// reset: synchronous, clears all stage valids, queue pointers and the serializer
module hangul_jamo_decomposer_unit import hjd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] req_code_unit,
   input  logic        req_push,
   output logic        req_full,
   output logic [15:0] rsp_jamo_unit,
   output logic        rsp_run_last,
   output logic        rsp_empty,
   input  logic        rsp_pop
);

   logic    q_push, q_full, q_pop, q_empty;
   run_type q_in_run, q_out_run;

   hjd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_code_unit (req_code_unit),
      .req_push      (req_push),
      .req_full      (req_full),
      .q_push        (q_push),
      .q_run         (q_in_run),
      .q_full        (q_full)
   );

   hjd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_run (q_in_run),
      .full     (q_full),
      .pop      (q_pop),
      .pop_run  (q_out_run),
      .empty    (q_empty)
   );

   hjd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_run         (q_out_run),
      .q_pop         (q_pop),
      .rsp_jamo_unit (rsp_jamo_unit),
      .rsp_run_last  (rsp_run_last),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop)
   );

endmodule
